/* sv/size_budget_lru_cache_unit_macros.svh */
// assertion helpers for the cache rtl
`ifndef SIZE_BUDGET_LRU_CACHE_UNIT_MACROS_SVH
`define SIZE_BUDGET_LRU_CACHE_UNIT_MACROS_SVH

// plain check on every edge outside reset
`define SBLC_ASSERT(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define SBLC_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SBLC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/sblc_pkg.sv */
package sblc_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam int ID_BITS_DEF = 16;

   localparam int TILE_ID_W   = 16;
   localparam int TILE_SIZE_W = 32;
   localparam int LIMIT_W     = 40;
   localparam int BYTES_W     = 41;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 40'd1073741824;

   typedef struct packed {
      logic [TILE_ID_W-1:0]   tile_id;
      logic [TILE_SIZE_W-1:0] tile_size;
   } req_word_type;

   typedef struct packed {
      logic                   is_eviction;
      logic [TILE_ID_W-1:0]   result_id;
      logic                   hit;
      logic [BYTES_W-1:0]     bytes_used;
      logic                   last;
   } rsp_word_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic shift;
      logic drop;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_EVICT  = 3'b100
   } state_type;

endpackage

/* sv/sblc_cell.sv */
module sblc_cell #(
   parameter int ID_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sblc_pkg::cell_ctl_type           ctl,
   input  logic [ID_BITS-1:0]               key,
   input  logic                             prev_valid,
   input  logic [ID_BITS-1:0]               prev_id,
   input  logic [sblc_pkg::TILE_SIZE_W-1:0] prev_size,
   output logic                             valid,
   output logic [ID_BITS-1:0]               id,
   output logic [sblc_pkg::TILE_SIZE_W-1:0] size,
   output logic                             match
);
   import sblc_pkg::*;

   logic                   valid_ff, valid_in;
   logic [ID_BITS-1:0]     id_ff, id_in;
   logic [TILE_SIZE_W-1:0] size_ff, size_in;

   // a shift takes the neighbor's entry, one step further from most recent
   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      size_in  = size_ff;
      if (ctl.shift) begin
         valid_in = prev_valid;
         id_in    = prev_id;
         size_in  = prev_size;
      end else if (ctl.drop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      size_ff <= size_in;
   end

   assign valid = valid_ff;
   assign id    = id_ff;
   assign size  = size_ff;
   assign match = valid_ff && (id_ff == key);

endmodule

/* sv/size_budget_lru_cache_unit.sv */
// a hit gives its word from the lookup state; a miss gives one word per
//   eviction from the evict state, then the final insert word
// a new request is taken only in the idle state, after the final word of the last
//   one; the eviction sequencer steps once per word and holds while rsp_stall blocks it
// reset: synchronous, empties every cell, clears bytes in use, limit to 1 GiB
module size_budget_lru_cache_unit #(
   parameter int ENTRIES = sblc_pkg::ENTRIES_DEF,
   parameter int ID_BITS = sblc_pkg::ID_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  sblc_pkg::req_word_type       req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sblc_pkg::rsp_word_type       rsp_word,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sblc_pkg::LIMIT_W-1:0] csr_data
);
   import sblc_pkg::*;
   `include "size_budget_lru_cache_unit_macros.svh"

   state_type state_ff, state_in;

   logic [LIMIT_W-1:0]     limit_ff;
   logic [BYTES_W-1:0]     bytes_ff, bytes_in;
   logic [ID_BITS-1:0]     key_ff;
   logic [TILE_SIZE_W-1:0] size_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic [ENTRIES-1:0]     valid_vec, match_vec, drop_vec, shift_hit;
   logic [ID_BITS-1:0]     id_arr [ENTRIES];
   logic [TILE_SIZE_W-1:0] size_arr [ENTRIES];
   cell_ctl_type           ctl_arr [ENTRIES];

   logic [TILE_SIZE_W-1:0] hit_size, ev_size, head_size;
   logic [ID_BITS-1:0]     ev_id;
   logic                   any_match, full, over, need_evict, out_free;
   logic                   do_accept, do_hit, do_evict, do_insert;
   logic [BYTES_W:0]       demand;

   // cell 0 is most recently used, valid cells fill from 0 upward
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_head
         sblc_cell #(.ID_BITS(ID_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl_arr[i]),
            .key        (key_ff),
            .prev_valid (1'b1),
            .prev_id    (key_ff),
            .prev_size  (head_size),
            .valid      (valid_vec[i]),
            .id         (id_arr[i]),
            .size       (size_arr[i]),
            .match      (match_vec[i])
         );
      end else begin : g_body
         sblc_cell #(.ID_BITS(ID_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl_arr[i]),
            .key        (key_ff),
            .prev_valid (valid_vec[i-1]),
            .prev_id    (id_arr[i-1]),
            .prev_size  (size_arr[i-1]),
            .valid      (valid_vec[i]),
            .id         (id_arr[i]),
            .size       (size_arr[i]),
            .match      (match_vec[i])
         );
      end

      // least recently used is the last valid cell
      if (i == ENTRIES - 1) begin : g_tail
         assign drop_vec[i] = valid_vec[i];
      end else begin : g_mid
         assign drop_vec[i] = valid_vec[i] && !valid_vec[i+1];
      end

      // on a hit, cells up to the hit position move down by one
      assign shift_hit[i] = |(match_vec >> i);

      assign ctl_arr[i].shift = do_insert || (do_hit && shift_hit[i]);
      assign ctl_arr[i].drop  = do_evict && drop_vec[i];
   end

   always_comb begin
      hit_size = '0;
      ev_size  = '0;
      ev_id    = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_vec[i]) begin
            hit_size = hit_size | size_arr[i];
         end
         if (drop_vec[i]) begin
            ev_size = ev_size | size_arr[i];
            ev_id   = ev_id | id_arr[i];
         end
      end
   end

   assign any_match  = |match_vec;
   assign full       = valid_vec[ENTRIES-1];
   assign demand     = {1'b0, bytes_ff} + (BYTES_W+1)'(size_ff);
   assign over       = (bytes_ff != '0) && (demand > (BYTES_W+1)'(limit_ff));
   assign need_evict = over || full;
   assign head_size  = do_hit ? hit_size : size_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign do_accept = (state_ff == ST_IDLE) && req_valid;
   assign do_hit    = (state_ff == ST_LOOKUP) && out_free && any_match;
   assign do_evict  = (state_ff == ST_EVICT) && out_free && need_evict;
   assign do_insert = (state_ff == ST_EVICT) && out_free && !need_evict;

   always_comb begin
      state_in     = state_ff;
      bytes_in     = bytes_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (do_hit) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.is_eviction = 1'b0;
               rsp_word_in.result_id   = TILE_ID_W'(key_ff);
               rsp_word_in.hit         = 1'b1;
               rsp_word_in.bytes_used  = bytes_ff;
               rsp_word_in.last        = 1'b1;
               state_in                = ST_IDLE;
            end else if (out_free) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if (do_evict) begin
               bytes_in                = bytes_ff - BYTES_W'(ev_size);
               rsp_valid_in            = 1'b1;
               rsp_word_in.is_eviction = 1'b1;
               rsp_word_in.result_id   = TILE_ID_W'(ev_id);
               rsp_word_in.hit         = 1'b0;
               rsp_word_in.bytes_used  = bytes_ff - BYTES_W'(ev_size);
               rsp_word_in.last        = 1'b0;
            end else if (do_insert) begin
               bytes_in                = bytes_ff + BYTES_W'(size_ff);
               rsp_valid_in            = 1'b1;
               rsp_word_in.is_eviction = 1'b0;
               rsp_word_in.result_id   = TILE_ID_W'(key_ff);
               rsp_word_in.hit         = 1'b0;
               rsp_word_in.bytes_used  = bytes_ff + BYTES_W'(size_ff);
               rsp_word_in.last        = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bytes_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (do_accept) begin
         key_ff  <= ID_BITS'(req_word.tile_id);
         size_ff <= req_word.tile_size;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign csr_ready = 1'b1;

   `SBLC_ASSERT(a_cells_packed, clock, reset, (valid_vec & (valid_vec + 1'b1)) == '0, "valid cells not packed from the head")
   `SBLC_ASSERT(a_single_match, clock, reset, $onehot0(match_vec), "tile id held in more than one cell")
   `SBLC_ASSERT_IMPL(a_one_victim, clock, reset, (state_ff == ST_EVICT) && need_evict, $onehot(drop_vec), "eviction without a single victim cell")
   `SBLC_ASSERT_NEXT(a_hit_word, clock, reset, do_hit, rsp_valid_ff && rsp_word_ff.hit && rsp_word_ff.last, "hit did not produce a final hit word")

endmodule

/* tb/sv/size_budget_lru_cache_checker.sv */
`timescale 1ns / 100ps

module size_budget_lru_cache_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  sblc_pkg::req_word_type       req_word,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  sblc_pkg::rsp_word_type       rsp_word,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [sblc_pkg::LIMIT_W-1:0] csr_data,
   output int                           mismatch_count,
   output int                           words_due
);
   import sblc_pkg::*;

   localparam int CELLS      = ENTRIES_DEF;
   localparam int REPORT_MAX = 10;

   logic [TILE_ID_W-1:0]   cell_id   [CELLS];
   logic [TILE_SIZE_W-1:0] cell_size [CELLS];
   bit                     cell_live [CELLS];
   int unsigned            cell_age  [CELLS];  // 0 is most recently used
   logic [BYTES_W-1:0]     held_bytes;
   logic [LIMIT_W-1:0]     budget;
   rsp_word_type           replies_due [$];
   int                     misses = 0;

   // evicts the least recently used cell and queues its eviction word
   function automatic bit drop_oldest();
      int v;
      int i;
      rsp_word_type w;
      v = -1;
      for (i = 0; i < CELLS; i++) begin
         if (cell_live[i] && (v < 0 || cell_age[i] > cell_age[v])) v = i;
      end
      if (v < 0) return 1'b0;
      cell_live[v] = 1'b0;
      held_bytes   = held_bytes - BYTES_W'(cell_size[v]);
      w.is_eviction = 1'b1;
      w.result_id   = cell_id[v];
      w.hit         = 1'b0;
      w.bytes_used  = held_bytes;
      w.last        = 1'b0;
      replies_due.insert(replies_due.size(), w);
      return 1'b1;
   endfunction

   function automatic void serve_tile(input req_word_type r);
      int hit_cell;
      int free_cell;
      int live;
      int evicted;
      int i;
      rsp_word_type w;
      hit_cell = -1;
      for (i = 0; i < CELLS; i++) begin
         if (cell_live[i] && cell_id[i] == r.tile_id && hit_cell < 0) hit_cell = i;
      end
      w.is_eviction = 1'b0;
      w.result_id   = r.tile_id;
      w.last        = 1'b1;
      if (hit_cell >= 0) begin
         for (i = 0; i < CELLS; i++) begin
            if (cell_live[i] && cell_age[i] < cell_age[hit_cell]) cell_age[i]++;
         end
         cell_age[hit_cell] = 0;
         w.hit        = 1'b1;
         w.bytes_used = held_bytes;
         replies_due.insert(replies_due.size(), w);
         return;
      end
      evicted = 0;
      while (held_bytes != '0 && evicted < CELLS &&
             ({1'b0, held_bytes} + 42'(r.tile_size)) > 42'(budget)) begin
         if (!drop_oldest()) break;
         evicted++;
      end
      live = 0;
      for (i = 0; i < CELLS; i++) begin
         if (cell_live[i]) live++;
      end
      // the slot count bounds the table even when the budget does not
      if (live >= CELLS) void'(drop_oldest());
      free_cell = -1;
      for (i = 0; i < CELLS; i++) begin
         if (!cell_live[i] && free_cell < 0) free_cell = i;
      end
      if (free_cell >= 0) begin
         for (i = 0; i < CELLS; i++) begin
            if (cell_live[i]) cell_age[i]++;
         end
         cell_live[free_cell] = 1'b1;
         cell_id[free_cell]   = r.tile_id;
         cell_size[free_cell] = r.tile_size;
         cell_age[free_cell]  = 0;
         held_bytes = held_bytes + BYTES_W'(r.tile_size);
      end
      w.hit        = 1'b0;
      w.bytes_used = held_bytes;
      replies_due.insert(replies_due.size(), w);
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type want;
      int i;
      if (reset) begin
         for (i = 0; i < CELLS; i++) begin
            cell_live[i] = 1'b0;
            cell_age[i]  = 0;
         end
         held_bytes = '0;
         budget     = LIMIT_RESET;
         replies_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               misses++;
               if (misses <= REPORT_MAX)
                  $display("%0t: unexpected reply word ev=%0b id=%h hit=%0b bytes=%0d last=%0b",
                           $realtime, rsp_word.is_eviction, rsp_word.result_id, rsp_word.hit,
                           rsp_word.bytes_used, rsp_word.last);
            end else begin
               want = replies_due.pop_front();
               if (want.is_eviction !== rsp_word.is_eviction ||
                   want.result_id !== rsp_word.result_id || want.hit !== rsp_word.hit ||
                   want.bytes_used !== rsp_word.bytes_used || want.last !== rsp_word.last) begin
                  misses++;
                  if (misses <= REPORT_MAX)
                     $display({"%0t: reply word mismatch, expected ev=%0b id=%h hit=%0b",
                               " bytes=%0d last=%0b, got ev=%0b id=%h hit=%0b bytes=%0d last=%0b"},
                              $realtime, want.is_eviction, want.result_id, want.hit,
                              want.bytes_used, want.last, rsp_word.is_eviction,
                              rsp_word.result_id, rsp_word.hit, rsp_word.bytes_used,
                              rsp_word.last);
               end
            end
         end
         if (csr_valid && csr_ready) budget = csr_data;
         if (req_valid && !req_stall) serve_tile(req_word);
      end
      mismatch_count <= misses;
      words_due      <= replies_due.size();
   end

endmodule

/* tb/sv/tb_size_budget_lru_cache_unit.sv */
`timescale 1ns / 100ps

module tb_size_budget_lru_cache_unit;
   import sblc_pkg::*;

   localparam int POOL_SIZE      = 20;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 56;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 24;
   localparam int WATCHDOG_LIMIT = 2000;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_word_type       req_word  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_word_type       rsp_word;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [LIMIT_W-1:0] csr_data  = '0;

   int                   mismatch_count;
   int                   words_due;
   int                   idle_cycles = 0;
   bit                   calm = 1'b0;
   logic [TILE_ID_W-1:0] tile_pool    [POOL_SIZE];
   logic [LIMIT_W-1:0]   phase_budget [PHASES];

   size_budget_lru_cache_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   size_budget_lru_cache_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic req_word_type random_tile(input logic [LIMIT_W-1:0] cap);
      req_word_type w;
      int unsigned pick;
      logic [LIMIT_W-1:0] span;
      // a pool a bit larger than the table gives hits and full-table evictions
      pick = $urandom_range(0, 99);
      w.tile_id = (pick < 75) ? tile_pool[$urandom_range(0, POOL_SIZE-1)]
                              : TILE_ID_W'($urandom);
      pick = $urandom_range(0, 99);
      span = cap >> 3;
      if (pick < 8) w.tile_size = '0;
      else if (pick < 14) w.tile_size = '1;
      else if (pick < 30 || span > 40'hFFFF_FFFF) w.tile_size = $urandom;
      else w.tile_size = $urandom_range(0, (span == '0) ? 15 : 32'(span));
      return w;
   endfunction

   task automatic send_tile(input req_word_type w);
      int gap;
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_budget(input logic [LIMIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : rsp_backpressure
      int open_cycles;
      int shut_cycles;
      forever begin
         open_cycles = $urandom_range(1, 12);
         shut_cycles = calm ? 0 : idle_len();
         repeat (open_cycles) @(posedge clock);
         if (shut_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (shut_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_size_budget_lru_cache_unit NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int n;
      int p;
      tile_pool[0] = '0;
      tile_pool[1] = '1;
      for (n = 2; n < POOL_SIZE; n++) tile_pool[n] = TILE_ID_W'($urandom);
      phase_budget[0] = '0;
      phase_budget[1] = '1;
      phase_budget[2] = LIMIT_RESET;
      phase_budget[3] = LIMIT_W'($urandom_range(1000, 200000));
      phase_budget[4] = {8'($urandom), 32'($urandom)};
      phase_budget[5] = 40'd4096;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset budget: zero size, hit ignoring size, exact fit, oversized tile
      send_tile('{16'h0000, 32'd0});
      send_tile('{16'h0000, 32'd123});
      send_tile('{16'hFFFF, 32'd100});
      send_tile('{16'h0001, 32'h4000_0000});
      send_tile('{16'h0002, 32'hFFFF_FFFF});
      // fill every slot, hit one of them, then one more to force the full-table eviction
      for (n = 3; n <= 18; n++) send_tile('{TILE_ID_W'(n), 32'd0});
      send_tile('{16'd10, 32'd0});
      send_tile('{16'hFFFF, 32'd1});
      wait_drained();
      // zero budget: a miss evicts until no bytes are held
      write_budget('0);
      send_tile('{16'd5, 32'd7});
      send_tile('{16'd6, 32'd0});

      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         calm = (p == 3);
         write_budget(phase_budget[p]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_tile(random_tile(phase_budget[p]));
            if ($urandom_range(0, 29) == 0) wait_drained();
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && words_due == 0) begin
         $display("tb_size_budget_lru_cache_unit OK");
      end else begin
         $display("tb_size_budget_lru_cache_unit NOT OK");
      end
      $finish;
   end

endmodule
